// ===== sv/pzdr_pkg.sv =====
// Shared types, constants and lookup functions for the pedal zone duty regulator.
package pzdr_pkg;

   localparam int PEDAL_W     = 7;
   localparam int STEPS_W     = 8;
   localparam int DUTY_W      = 9;
   localparam int RATE_W      = 6;
   localparam int SPEED_W     = 5;
   localparam int TICKS_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;
   localparam int NUMER_W     = 16;
   localparam int DIV_STEPS   = 16;
   localparam int STEP_CNT_W  = 4;

   localparam logic [DUTY_W-1:0]  STOP_DUTY   = 9'd500;
   localparam logic [PEDAL_W-1:0] PEDAL_FULL  = 7'd100;
   localparam logic [SPEED_W-1:0] SPEED_TOP   = 5'd30;
   localparam logic [SPEED_W-1:0] FLOOR_SPEED = 5'd25;
   localparam logic [TICKS_W-1:0] TICKS_FAST  = 6'd20;
   localparam logic [TICKS_W-1:0] TICKS_SLOW  = 6'd40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_SPEED,
      CSR_CONTROLLER_KIND,
      CSR_LAUNCH_START,
      CSR_RAMP_START,
      CSR_HOLD_START,
      CSR_RELAUNCH_START,
      CSR_BRAKE_START
   } csr_index_type;

   typedef enum logic [2:0] {
      ZONE_LAUNCH,
      ZONE_RAMP,
      ZONE_HOLD,
      ZONE_RELAUNCH,
      ZONE_NONE
   } zone_type;

   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_BASE,
      CORE_DUTY_GO,
      CORE_DUTY_WAIT,
      CORE_RATE_GO,
      CORE_RATE_WAIT,
      CORE_FINISH
   } core_state_type;

   typedef enum logic [2:0] {
      RATIO_IDLE,
      RATIO_MUL_LO,
      RATIO_MUL_HI,
      RATIO_DIV,
      RATIO_DONE
   } ratio_state_type;

   typedef struct packed {
      logic                 start;
      logic [DUTY_W-1:0]    lo_val;
      logic [DUTY_W-1:0]    hi_val;
      logic [PEDAL_W-1:0]   span;
      logic [PEDAL_W-1:0]   pos;
   } ratio_req_type;

   typedef struct packed {
      logic                 done;
      logic [NUMER_W-1:0]   quotient;
   } ratio_rsp_type;

   // Duty for a speed setting; settings above thirty count as thirty.
   function automatic logic [DUTY_W-1:0] duty_lookup(input logic kind,
                                                     input logic [SPEED_W-1:0] speed);
      logic [SPEED_W-1:0] s;
      logic [DUTY_W-1:0]  v;
      s = (speed > SPEED_TOP) ? SPEED_TOP : speed;
      v = STOP_DUTY;
      if (s == 5'd0) begin
         v = STOP_DUTY;
      end else if (!kind) begin
         // The first formula set drops by exactly seven per speed step.
         v = 9'd332 - ({1'b0, s, 3'b000} - {4'b0000, s});
      end else begin
         case (s)
            5'd1:    v = 9'd360;
            5'd2:    v = 9'd353;
            5'd3:    v = 9'd346;
            5'd4:    v = 9'd339;
            5'd5:    v = 9'd332;
            5'd6:    v = 9'd317;
            5'd7:    v = 9'd307;
            5'd8:    v = 9'd297;
            5'd9:    v = 9'd288;
            5'd10:   v = 9'd278;
            5'd11:   v = 9'd268;
            5'd12:   v = 9'd258;
            5'd13:   v = 9'd248;
            5'd14:   v = 9'd238;
            5'd15:   v = 9'd229;
            5'd16:   v = 9'd219;
            5'd17:   v = 9'd209;
            5'd18:   v = 9'd199;
            5'd19:   v = 9'd189;
            5'd20:   v = 9'd179;
            5'd21:   v = 9'd169;
            5'd22:   v = 9'd160;
            5'd23:   v = 9'd150;
            5'd24:   v = 9'd140;
            5'd25:   v = 9'd130;
            5'd26:   v = 9'd120;
            5'd27:   v = 9'd110;
            5'd28:   v = 9'd100;
            5'd29:   v = 9'd100;
            5'd30:   v = 9'd100;
            default: v = STOP_DUTY;
         endcase
      end
      return v;
   endfunction

   // Target step rate for a speed setting, never below one.
   function automatic logic [RATE_W-1:0] rate_lookup(input logic [SPEED_W-1:0] speed);
      logic [SPEED_W-1:0] s;
      logic [RATE_W-1:0]  v;
      s = (speed > SPEED_TOP) ? SPEED_TOP : speed;
      case (s)
         5'd0:    v = 6'd1;
         5'd1:    v = 6'd2;
         5'd2:    v = 6'd3;
         5'd3:    v = 6'd5;
         5'd4:    v = 6'd7;
         5'd5:    v = 6'd8;
         5'd6:    v = 6'd10;
         5'd7:    v = 6'd11;
         5'd8:    v = 6'd13;
         5'd9:    v = 6'd15;
         5'd10:   v = 6'd16;
         5'd11:   v = 6'd18;
         5'd12:   v = 6'd20;
         5'd13:   v = 6'd21;
         5'd14:   v = 6'd23;
         5'd15:   v = 6'd24;
         5'd16:   v = 6'd26;
         5'd17:   v = 6'd28;
         5'd18:   v = 6'd29;
         5'd19:   v = 6'd31;
         5'd20:   v = 6'd33;
         5'd21:   v = 6'd34;
         5'd22:   v = 6'd36;
         5'd23:   v = 6'd38;
         5'd24:   v = 6'd39;
         5'd25:   v = 6'd41;
         5'd26:   v = 6'd42;
         5'd27:   v = 6'd44;
         5'd28:   v = 6'd46;
         5'd29:   v = 6'd47;
         5'd30:   v = 6'd49;
         default: v = 6'd49;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/pzdr_req_if.sv =====
// Request channel interface: pedal position and measured step rate.
interface pzdr_req_if;
   logic                          valid;
   logic                          ready;
   logic [pzdr_pkg::PEDAL_W-1:0]  pedal;
   logic [pzdr_pkg::STEPS_W-1:0]  measured_steps;

   modport source (output valid, output pedal, output measured_steps, input ready);
   modport sink   (input valid, input pedal, input measured_steps, output ready);
endinterface

// ===== sv/pzdr_rsp_if.sv =====
// Response channel interface: regulated duty value.
interface pzdr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pzdr_pkg::DUTY_W-1:0]  duty;

   modport source (output valid, output duty, input ready);
   modport sink   (input valid, input duty, output ready);
endinterface

// ===== sv/pzdr_ratio.sv =====
// Iterative interpolation unit: (lo*(span-pos) + hi*pos) / span, one quotient bit per cycle.
module pzdr_ratio (
   input  logic                    clock,
   input  logic                    reset,
   input  pzdr_pkg::ratio_req_type ratio_req,
   output pzdr_pkg::ratio_rsp_type ratio_rsp
);

   pzdr_pkg::ratio_state_type state_ff, state_in;

   logic [pzdr_pkg::DUTY_W-1:0]     lo_ff, lo_in;
   logic [pzdr_pkg::DUTY_W-1:0]     hi_ff, hi_in;
   logic [pzdr_pkg::PEDAL_W-1:0]    span_ff, span_in;
   logic [pzdr_pkg::PEDAL_W-1:0]    pos_ff, pos_in;
   logic [pzdr_pkg::NUMER_W-1:0]    acc_ff, acc_in;
   logic [pzdr_pkg::PEDAL_W-1:0]    rem_ff, rem_in;
   logic [pzdr_pkg::STEP_CNT_W-1:0] step_ff, step_in;

   logic [pzdr_pkg::DUTY_W-1:0]     mul_a;
   logic [pzdr_pkg::PEDAL_W-1:0]    mul_b;
   logic [pzdr_pkg::NUMER_W-1:0]    product;
   logic [pzdr_pkg::PEDAL_W:0]      trial;
   logic [pzdr_pkg::PEDAL_W+1:0]    diff;
   logic                            fits;

   // One multiplier serves both weighted terms; the divide reuses the accumulator.
   assign mul_a   = (state_ff == pzdr_pkg::RATIO_MUL_LO) ? lo_ff : hi_ff;
   assign mul_b   = (state_ff == pzdr_pkg::RATIO_MUL_LO) ? (span_ff - pos_ff) : pos_ff;
   assign product = pzdr_pkg::NUMER_W'(mul_a) * pzdr_pkg::NUMER_W'(mul_b);

   assign trial = {rem_ff, acc_ff[pzdr_pkg::NUMER_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, span_ff};
   assign fits  = !diff[pzdr_pkg::PEDAL_W+1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pzdr_pkg::RATIO_IDLE: begin
            if (ratio_req.start) state_in = pzdr_pkg::RATIO_MUL_LO;
         end
         pzdr_pkg::RATIO_MUL_LO: state_in = pzdr_pkg::RATIO_MUL_HI;
         pzdr_pkg::RATIO_MUL_HI: state_in = pzdr_pkg::RATIO_DIV;
         pzdr_pkg::RATIO_DIV: begin
            if (step_ff == pzdr_pkg::STEP_CNT_W'(pzdr_pkg::DIV_STEPS - 1)) begin
               state_in = pzdr_pkg::RATIO_DONE;
            end
         end
         pzdr_pkg::RATIO_DONE: state_in = pzdr_pkg::RATIO_IDLE;
         default: state_in = pzdr_pkg::RATIO_IDLE;
      endcase
   end

   always_comb begin
      ratio_rsp.done     = (state_ff == pzdr_pkg::RATIO_DONE);
      ratio_rsp.quotient = acc_ff;
   end

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      span_in = span_ff;
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      case (state_ff)
         pzdr_pkg::RATIO_IDLE: begin
            lo_in   = ratio_req.lo_val;
            hi_in   = ratio_req.hi_val;
            span_in = ratio_req.span;
            pos_in  = ratio_req.pos;
            rem_in  = '0;
            step_in = '0;
         end
         pzdr_pkg::RATIO_MUL_LO: acc_in = product;
         pzdr_pkg::RATIO_MUL_HI: acc_in = acc_ff + product;
         pzdr_pkg::RATIO_DIV: begin
            // Restoring step: the remainder stays below the divisor, so it fits.
            rem_in  = fits ? diff[pzdr_pkg::PEDAL_W-1:0] : trial[pzdr_pkg::PEDAL_W-1:0];
            acc_in  = {acc_ff[pzdr_pkg::NUMER_W-2:0], fits};
            step_in = step_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pzdr_pkg::RATIO_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      span_ff <= span_in;
      pos_ff  <= pos_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

// ===== sv/pedal_zone_duty_regulator_core.sv =====
// Top level of the pedal zone duty regulator: zone selection, sequencing and regulation.
//
//   channel   direction  payload                       transfer when
//   req_bus   in         pedal[6:0], measured_steps[7:0]  valid && ready
//   rsp_bus   out        duty[8:0]                      valid && ready
//   csr_*     in         index[2:0], data[6:0]          csr_write
//
// An item outside the ramp zone passes from zone decode straight to its finish step. In the
// ramp zone the interpolation unit runs twice (duty, then rate), each run doing two
// multiplies and a 16-step restoring divide before the result is registered for rsp_bus.
// One item is in work at a time; req_bus.ready is high only while the sequencer idles.
// A result waiting on rsp_bus holds the next item in its last step until taken.
// Reset is synchronous and loads the register defaults with cleared regulator state.
module pedal_zone_duty_regulator_core (
   input  logic                              clock,
   input  logic                              reset,
   pzdr_req_if.sink                          req_bus,
   pzdr_rsp_if.source                        rsp_bus,
   input  logic                              csr_write,
   input  logic [pzdr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pzdr_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam logic signed [11:0] BAND_LOW   = 12'sd60;
   localparam logic signed [11:0] BAND_GUARD = 12'sd5;
   localparam logic signed [11:0] BAND_HOLD  = 12'sd20;
   localparam logic [4:0]         DEC_MAX    = 5'd15;

   pzdr_pkg::core_state_type state_ff, state_in;

   logic [pzdr_pkg::SPEED_W-1:0] max_speed_ff;
   logic                         kind_ff;
   logic [pzdr_pkg::PEDAL_W-1:0] launch_ff, ramp_ff, hold_ff, relaunch_ff, brake_ff;

   logic [pzdr_pkg::PEDAL_W-1:0] pedal_ff, pedal_in;
   logic [pzdr_pkg::STEPS_W-1:0] steps_ff, steps_in;
   logic [pzdr_pkg::DUTY_W-1:0]  base_duty_ff, base_duty_in;
   logic [pzdr_pkg::RATE_W-1:0]  base_rate_ff, base_rate_in;
   pzdr_pkg::zone_type           zone_ff, zone_in;
   logic [pzdr_pkg::DUTY_W-1:0]  held_ff, held_in;
   logic [pzdr_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic [pzdr_pkg::DUTY_W-1:0]  rsp_duty_ff, rsp_duty_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   pzdr_pkg::ratio_req_type ratio_req;
   pzdr_pkg::ratio_rsp_type ratio_rsp;

   logic [pzdr_pkg::SPEED_W-1:0] launch_speed;
   logic [pzdr_pkg::DUTY_W-1:0]  duty_lo, duty_hi, floor_duty;
   logic [pzdr_pkg::RATE_W-1:0]  rate_lo, rate_hi;
   logic in_brake, in_relaunch, in_hold, in_ramp, in_launch;
   logic interp;
   logic [pzdr_pkg::DUTY_W-1:0]  sel_duty;
   logic [pzdr_pkg::RATE_W-1:0]  sel_rate;
   pzdr_pkg::zone_type           sel_zone;

   logic out_free;
   logic capture, take_base, take_duty_q, take_rate_q, finish_load;

   logic signed [11:0]           held_work, base_s, floor_s;
   logic [pzdr_pkg::TICKS_W-1:0] ticks_work;
   logic [8:0]                   steps9, rate9;
   logic [7:0]                   gap_half;
   logic [4:0]                   dec_amt;

   pzdr_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .ratio_req (ratio_req),
      .ratio_rsp (ratio_rsp)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= '0;
         kind_ff      <= 1'b0;
         launch_ff    <= 7'd10;
         ramp_ff      <= 7'd25;
         hold_ff      <= 7'd65;
         relaunch_ff  <= 7'd85;
         brake_ff     <= 7'd90;
      end else if (csr_write) begin
         case (csr_index)
            pzdr_pkg::CSR_MAX_SPEED:       max_speed_ff <= csr_data[pzdr_pkg::SPEED_W-1:0];
            pzdr_pkg::CSR_CONTROLLER_KIND: kind_ff      <= csr_data[0];
            pzdr_pkg::CSR_LAUNCH_START:    launch_ff    <= csr_data;
            pzdr_pkg::CSR_RAMP_START:      ramp_ff      <= csr_data;
            pzdr_pkg::CSR_HOLD_START:      hold_ff      <= csr_data;
            pzdr_pkg::CSR_RELAUNCH_START:  relaunch_ff  <= csr_data;
            pzdr_pkg::CSR_BRAKE_START:     brake_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Curve end points come straight from the static configuration.
   assign launch_speed = (max_speed_ff > 5'd2) ? 5'd2 : 5'd1;
   assign duty_lo      = pzdr_pkg::duty_lookup(kind_ff, launch_speed);
   assign duty_hi      = pzdr_pkg::duty_lookup(kind_ff, max_speed_ff);
   assign rate_lo      = pzdr_pkg::rate_lookup(launch_speed);
   assign rate_hi      = pzdr_pkg::rate_lookup(max_speed_ff);
   assign floor_duty   = pzdr_pkg::duty_lookup(kind_ff, pzdr_pkg::FLOOR_SPEED);

   assign in_brake    = (pedal_ff >= brake_ff) && (pedal_ff < pzdr_pkg::PEDAL_FULL);
   assign in_relaunch = (pedal_ff >= relaunch_ff) && (pedal_ff < brake_ff);
   assign in_hold     = (pedal_ff >= hold_ff) && (pedal_ff < relaunch_ff);
   assign in_ramp     = (pedal_ff >= ramp_ff) && (pedal_ff < hold_ff);
   assign in_launch   = (pedal_ff >= launch_ff) && (pedal_ff < ramp_ff);

   // Base values favor the upper zones; regulation favors the lower ones.
   always_comb begin
      interp   = 1'b0;
      sel_duty = pzdr_pkg::STOP_DUTY;
      sel_rate = '0;
      if (in_brake) begin
         sel_duty = pzdr_pkg::STOP_DUTY;
         sel_rate = '0;
      end else if (in_relaunch) begin
         sel_duty = duty_lo;
         sel_rate = rate_lo;
      end else if (in_hold) begin
         sel_duty = duty_hi;
         sel_rate = rate_hi;
      end else if (in_ramp) begin
         interp = 1'b1;
      end else if (in_launch) begin
         sel_duty = duty_lo;
         sel_rate = rate_lo;
      end

      if (in_launch) begin
         sel_zone = pzdr_pkg::ZONE_LAUNCH;
      end else if (in_ramp) begin
         sel_zone = pzdr_pkg::ZONE_RAMP;
      end else if (in_hold) begin
         sel_zone = pzdr_pkg::ZONE_HOLD;
      end else if (in_relaunch) begin
         sel_zone = pzdr_pkg::ZONE_RELAUNCH;
      end else begin
         sel_zone = pzdr_pkg::ZONE_NONE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pzdr_pkg::CORE_IDLE: begin
            if (req_bus.valid) state_in = pzdr_pkg::CORE_BASE;
         end
         pzdr_pkg::CORE_BASE: begin
            state_in = interp ? pzdr_pkg::CORE_DUTY_GO : pzdr_pkg::CORE_FINISH;
         end
         pzdr_pkg::CORE_DUTY_GO: state_in = pzdr_pkg::CORE_DUTY_WAIT;
         pzdr_pkg::CORE_DUTY_WAIT: begin
            if (ratio_rsp.done) state_in = pzdr_pkg::CORE_RATE_GO;
         end
         pzdr_pkg::CORE_RATE_GO: state_in = pzdr_pkg::CORE_RATE_WAIT;
         pzdr_pkg::CORE_RATE_WAIT: begin
            if (ratio_rsp.done) state_in = pzdr_pkg::CORE_FINISH;
         end
         pzdr_pkg::CORE_FINISH: begin
            if (out_free) state_in = pzdr_pkg::CORE_IDLE;
         end
         default: state_in = pzdr_pkg::CORE_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_bus.ready    = 1'b0;
      capture          = 1'b0;
      take_base        = 1'b0;
      take_duty_q      = 1'b0;
      take_rate_q      = 1'b0;
      finish_load      = 1'b0;
      ratio_req.start  = 1'b0;
      ratio_req.lo_val = duty_lo;
      ratio_req.hi_val = duty_hi;
      ratio_req.span   = hold_ff - ramp_ff;
      ratio_req.pos    = pedal_ff - ramp_ff;
      case (state_ff)
         pzdr_pkg::CORE_IDLE: begin
            req_bus.ready = 1'b1;
            capture       = req_bus.valid;
         end
         pzdr_pkg::CORE_BASE: take_base = 1'b1;
         pzdr_pkg::CORE_DUTY_GO: ratio_req.start = 1'b1;
         pzdr_pkg::CORE_DUTY_WAIT: take_duty_q = ratio_rsp.done;
         pzdr_pkg::CORE_RATE_GO: begin
            ratio_req.start  = 1'b1;
            ratio_req.lo_val = {3'b000, rate_lo};
            ratio_req.hi_val = {3'b000, rate_hi};
         end
         pzdr_pkg::CORE_RATE_WAIT: take_rate_q = ratio_rsp.done;
         pzdr_pkg::CORE_FINISH: finish_load = out_free;
         default: begin
         end
      endcase
   end

   // Regulation of the kept duty for the finished item.
   assign steps9   = {1'b0, steps_ff};
   assign rate9    = {3'b000, base_rate_ff};
   assign gap_half = 8'((rate9 - steps9) >> 1);
   assign base_s   = signed'({3'b000, base_duty_ff});
   assign floor_s  = signed'({3'b000, floor_duty});

   always_comb begin
      if (gap_half > 8'd1 && gap_half < 8'd8) begin
         dec_amt = gap_half[4:0];
      end else if (gap_half <= 8'd1) begin
         dec_amt = 5'd1;
      end else begin
         dec_amt = DEC_MAX;
      end
   end

   always_comb begin
      held_work  = signed'({3'b000, held_ff});
      ticks_work = ticks_ff;
      case (zone_ff)
         pzdr_pkg::ZONE_LAUNCH: held_work = base_s;
         pzdr_pkg::ZONE_RAMP, pzdr_pkg::ZONE_HOLD, pzdr_pkg::ZONE_RELAUNCH: begin
            if (held_work == signed'({3'b000, pzdr_pkg::STOP_DUTY})) held_work = base_s;
            if (rate9 <= 9'd3) begin
               if (steps9 + 9'd1 <= rate9) begin
                  if (ticks_work >= pzdr_pkg::TICKS_FAST) begin
                     if (held_work > base_s - BAND_LOW) held_work = held_work - 12'sd1;
                     ticks_work = '0;
                  end
                  ticks_work = ticks_work + 1'b1;
               end else if (steps9 > rate9 + 9'd1) begin
                  if (ticks_work >= pzdr_pkg::TICKS_FAST) begin
                     if (held_work < base_s) held_work = held_work + 12'sd1;
                     ticks_work = '0;
                  end
                  ticks_work = ticks_work + 1'b1;
               end else begin
                  held_work = base_s;
               end
            end else if (steps9 + 9'd3 < rate9) begin
               if (ticks_work >= pzdr_pkg::TICKS_FAST) begin
                  // The ramp zone only pulls the duty down near its base value.
                  if (zone_ff != pzdr_pkg::ZONE_RAMP || held_work > base_s - BAND_GUARD) begin
                     held_work = held_work - signed'({7'b0000000, dec_amt});
                  end
                  ticks_work = '0;
               end
               ticks_work = ticks_work + 1'b1;
            end else if (steps9 > rate9 + 9'd3) begin
               if (ticks_work >= pzdr_pkg::TICKS_SLOW) begin
                  if (held_work < base_s + BAND_GUARD) held_work = held_work + 12'sd1;
                  ticks_work = '0;
               end
               ticks_work = ticks_work + 1'b1;
            end else if (held_work > base_s + BAND_HOLD || held_work < base_s - BAND_HOLD) begin
               held_work = base_s;
            end
         end
         default: held_work = signed'({3'b000, pzdr_pkg::STOP_DUTY});
      endcase
      // The floor is always positive, so it also covers a decrement below zero.
      if (held_work < floor_s) held_work = floor_s;
   end

   // Datapath next values.
   always_comb begin
      pedal_in     = capture ? req_bus.pedal : pedal_ff;
      steps_in     = capture ? req_bus.measured_steps : steps_ff;
      base_duty_in = base_duty_ff;
      base_rate_in = base_rate_ff;
      zone_in      = zone_ff;
      if (take_base) begin
         base_duty_in = sel_duty;
         base_rate_in = sel_rate;
         zone_in      = sel_zone;
      end
      if (take_duty_q) base_duty_in = ratio_rsp.quotient[pzdr_pkg::DUTY_W-1:0];
      if (take_rate_q) base_rate_in = ratio_rsp.quotient[pzdr_pkg::RATE_W-1:0];
      held_in      = finish_load ? held_work[pzdr_pkg::DUTY_W-1:0] : held_ff;
      ticks_in     = finish_load ? ticks_work : ticks_ff;
      rsp_duty_in  = finish_load ? held_work[pzdr_pkg::DUTY_W-1:0] : rsp_duty_ff;
      if (finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pzdr_pkg::CORE_IDLE;
         held_ff      <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pedal_ff     <= pedal_in;
      steps_ff     <= steps_in;
      base_duty_ff <= base_duty_in;
      base_rate_ff <= base_rate_in;
      zone_ff      <= zone_in;
      rsp_duty_ff  <= rsp_duty_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.duty  = rsp_duty_ff;

   // A transfer on the request side always starts the zone decode next.
   a_accept_to_base: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == pzdr_pkg::CORE_BASE))
      else $error("request transfer did not start zone decode");

   // The interpolation unit only finishes while the sequencer waits for it.
   a_ratio_done_waited: assert property (@(posedge clock) disable iff (reset)
      ratio_rsp.done |-> (state_ff == pzdr_pkg::CORE_DUTY_WAIT ||
                          state_ff == pzdr_pkg::CORE_RATE_WAIT))
      else $error("interpolation finished with nobody waiting");

   // An interpolated value lies between its end points and so fits a duty.
   a_ratio_fits: assert property (@(posedge clock) disable iff (reset)
      ratio_rsp.done |-> (ratio_rsp.quotient[pzdr_pkg::NUMER_W-1:pzdr_pkg::DUTY_W] == '0))
      else $error("interpolated value out of range");

endmodule
